[hdl/esc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// esc_pkg
// shared widths, divide-by-constant reciprocals and the month start table
// ----------------------------------------------------------------------------
package esc_pkg;

    // field widths
    localparam int SecsW    = 32;
    localparam int YearW    = 12;
    localparam int MonthW   = 4;
    localparam int DomW     = 5;
    localparam int HourW    = 5;
    localparam int MinW     = 6;
    localparam int SecW     = 6;
    localparam int WdayW    = 3;
    localparam int DaysW    = 16;   // whole days since 1970, at most 49710
    localparam int TodW     = 17;   // seconds within the day, below 86400
    localparam int DoyW     = 9;    // day of year, 0..365

    // 86400 = 128 * 675; quotient by 675 as (x * DayRecip) >> DayShift, x < 2**25
    localparam logic [25:0] DayRecip  = 26'd50903317;
    localparam int          DayShift  = 35;
    localparam logic [9:0]  DayOdd    = 10'd675;

    // 3600 = 16 * 225; quotient by 225 as (x * HourRecip) >> 21, x < 5400
    localparam logic [13:0] HourRecip = 14'd9321;
    localparam int          HourShift = 21;
    localparam logic [11:0] SecsHour  = 12'd3600;

    // 60 = 4 * 15; quotient by 15 as (x * MinRecip) >> 14, x < 900
    localparam logic [10:0] MinRecip  = 11'd1093;
    localparam int          MinShift  = 14;
    localparam logic [5:0]  SecsMin   = 6'd60;

    // weekday: quotient by 7 as (x * WeekRecip) >> 19, x < 49715
    localparam logic [16:0] WeekRecip = 17'd74899;
    localparam int          WeekShift = 19;
    localparam logic [2:0]  WeekLen   = 3'd7;
    localparam logic [2:0]  BaseWday  = 3'd4;   // 1970-01-01 was a thursday

    // four-year cycles counted from 1968-01-01, a leap year
    localparam logic [16:0] QuadRecip = 17'd91868;  // (x * QuadRecip) >> 27, x < 50443
    localparam int          QuadShift = 27;
    localparam logic [10:0] QuadLen   = 11'd1461;
    localparam logic [9:0]  DaysTo1970 = 10'd731;
    localparam logic [11:0] QuadBase  = 12'd1968;
    // 2100-03-01 as a day count; a phantom feb 29 is inserted from here on
    localparam logic [15:0] Skip2100  = 16'd47541;
    localparam logic [10:0] QuadY1    = 11'd366;
    localparam logic [10:0] QuadY2    = 11'd731;
    localparam logic [10:0] QuadY3    = 11'd1096;

    localparam logic [MonthW-1:0] MonthsLast = 4'd11;

    // first day of year of month index idx (0 is january)
    function automatic logic [DoyW-1:0] month_start(input logic [MonthW-1:0] idx,
                                                    input logic leap);
        logic [DoyW-1:0] base;
        logic [DoyW-1:0] extra;
        begin
            case (idx)
                4'd0:    base = 9'd0;
                4'd1:    base = 9'd31;
                4'd2:    base = 9'd59;
                4'd3:    base = 9'd90;
                4'd4:    base = 9'd120;
                4'd5:    base = 9'd151;
                4'd6:    base = 9'd181;
                4'd7:    base = 9'd212;
                4'd8:    base = 9'd243;
                4'd9:    base = 9'd273;
                4'd10:   base = 9'd304;
                4'd11:   base = 9'd334;
                default: base = 9'd0;
            endcase
            extra = (leap && (idx >= 4'd2)) ? 9'd1 : 9'd0;
            month_start = base + extra;
        end
    endfunction

endpackage
`default_nettype wire

[hdl/esc_tod.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// esc_tod
// splits seconds of the day into hour, minute and second over six stages
// ----------------------------------------------------------------------------
module esc_tod (
    input  wire                       clk,
    input  wire  [esc_pkg::TodW-1:0]  tod,
    output logic [esc_pkg::HourW-1:0] hour,
    output logic [esc_pkg::MinW-1:0]  minute,
    output logic [esc_pkg::SecW-1:0]  second
);
    import esc_pkg::*;

    logic [26:0]       hour_prod;
    logic [HourW-1:0]  hour3_reg, hour3_next;
    logic [TodW-1:0]   tod3_reg;
    logic [11:0]       mod4_reg, mod4_next;
    logic [HourW-1:0]  hour4_reg;
    logic [20:0]       min_prod;
    logic [MinW-1:0]   min5_reg, min5_next;
    logic [11:0]       mod5_reg;
    logic [HourW-1:0]  hour5_reg;
    logic [HourW-1:0]  hour6_reg, hour7_reg, hour8_reg;
    logic [MinW-1:0]   min6_reg, min7_reg, min8_reg;
    logic [SecW-1:0]   sec6_reg, sec6_next, sec7_reg, sec8_reg;
    logic [TodW-1:0]   hour_secs;
    logic [11:0]       min_secs;

    always_comb
    begin
        hour_prod  = 27'(tod[TodW-1:4]) * 27'(HourRecip);
        hour3_next = hour_prod[HourShift +: HourW];
        // up to 23 * 3600, needs the full seconds-of-day width
        hour_secs  = 17'(hour3_reg) * 17'(SecsHour);
        mod4_next  = 12'(tod3_reg - hour_secs);
        min_prod   = 21'(mod4_reg[11:2]) * 21'(MinRecip);
        min5_next  = min_prod[MinShift +: MinW];
        min_secs   = 12'(min5_reg) * 12'(SecsMin);
        sec6_next  = 6'(mod5_reg - min_secs);
    end

    always_ff @(posedge clk)
    begin
        hour3_reg <= hour3_next;
        tod3_reg  <= tod;
        mod4_reg  <= mod4_next;
        hour4_reg <= hour3_reg;
        min5_reg  <= min5_next;
        mod5_reg  <= mod4_reg;
        hour5_reg <= hour4_reg;
        hour6_reg <= hour5_reg;
        min6_reg  <= min5_reg;
        sec6_reg  <= sec6_next;
        // align with the date path
        hour7_reg <= hour6_reg;
        min7_reg  <= min6_reg;
        sec7_reg  <= sec6_reg;
        hour8_reg <= hour7_reg;
        min8_reg  <= min7_reg;
        sec8_reg  <= sec7_reg;
    end

    assign hour   = hour8_reg;
    assign minute = min8_reg;
    assign second = sec8_reg;

endmodule
`default_nettype wire

[hdl/esc_date.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// esc_date
// day count to year, month, day of month and weekday over six stages
// ----------------------------------------------------------------------------
module esc_date (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        in_valid,
    input  wire  [esc_pkg::DaysW-1:0]  days,
    output logic                       out_valid,
    output logic [esc_pkg::YearW-1:0]  year,
    output logic [esc_pkg::MonthW-1:0] month,
    output logic [esc_pkg::DomW-1:0]   day_of_month,
    output logic [esc_pkg::WdayW-1:0]  weekday
);
    import esc_pkg::*;

    logic [5:0]        vld_reg;

    // stage 3
    logic [DaysW-1:0]  dpp3_reg, dpp3_next;
    logic [DaysW-1:0]  day4_3_reg, day4_3_next;
    logic [12:0]       wq3_reg, wq3_next;
    logic [31:0]       week_prod;
    // stage 4
    logic [32:0]       quad_prod;
    logic [5:0]        q4_reg, q4_next;
    logic [DaysW-1:0]  dpp4_reg;
    logic [WdayW-1:0]  wd4_reg, wd4_next;
    logic [15:0]       wq_days;
    // stage 5
    logic [5:0]        q5_reg;
    logic [10:0]       r5_reg, r5_next;
    logic [WdayW-1:0]  wd5_reg;
    logic [15:0]       quad_days;
    // stage 6
    logic [YearW-1:0]  year6_reg, year6_next;
    logic [DoyW-1:0]   doy6_reg, doy6_next;
    logic              leap6_reg, leap6_next;
    logic [WdayW-1:0]  wd6_reg;
    logic [1:0]        yofs;
    // stage 7
    logic [MonthW-1:0] mon7_reg, mon7_next;
    logic [YearW-1:0]  year7_reg;
    logic [DoyW-1:0]   doy7_reg;
    logic              leap7_reg;
    logic [WdayW-1:0]  wd7_reg;
    // stage 8
    logic [MonthW-1:0] mon8_reg;
    logic [DomW-1:0]   dom8_reg, dom8_next;
    logic [YearW-1:0]  year8_reg;
    logic [WdayW-1:0]  wd8_reg;

    always_comb
    begin
        // stage 3: shift to the 1968 epoch, skip the missing 2100 leap day
        dpp3_next   = days + 16'(DaysTo1970) + ((days >= Skip2100) ? 16'd1 : 16'd0);
        day4_3_next = days + 16'(BaseWday);
        week_prod   = 32'(day4_3_next) * 32'(WeekRecip);
        wq3_next    = week_prod[WeekShift +: 13];

        // stage 4
        wq_days     = 16'(wq3_reg) * 16'(WeekLen);
        wd4_next    = 3'(day4_3_reg - wq_days);
        quad_prod   = 33'(dpp3_reg) * 33'(QuadRecip);
        q4_next     = quad_prod[QuadShift +: 6];

        // stage 5
        quad_days   = 16'(q4_reg) * 16'(QuadLen);
        r5_next     = 11'(dpp4_reg - quad_days);

        // stage 6: year within the four-year cycle
        if (r5_reg < QuadY1)
        begin
            yofs      = 2'd0;
            doy6_next = r5_reg[DoyW-1:0];
        end
        else if (r5_reg < QuadY2)
        begin
            yofs      = 2'd1;
            doy6_next = 9'(r5_reg - QuadY1);
        end
        else if (r5_reg < QuadY3)
        begin
            yofs      = 2'd2;
            doy6_next = 9'(r5_reg - QuadY2);
        end
        else
        begin
            yofs      = 2'd3;
            doy6_next = 9'(r5_reg - QuadY3);
        end
        leap6_next = (yofs == 2'd0);
        year6_next = QuadBase + {4'd0, q5_reg, 2'b00} + 12'(yofs);

        // stage 7: month index by parallel compares against month starts
        mon7_next = '0;
        for (int m = 1; m <= 11; m++)
        begin
            if (doy6_reg >= month_start(4'(m), leap6_reg))
            begin
                mon7_next = mon7_next + 4'd1;
            end
        end

        // stage 8
        dom8_next = 5'(doy7_reg - month_start(mon7_reg, leap7_reg) + 9'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        dpp3_reg   <= dpp3_next;
        day4_3_reg <= day4_3_next;
        wq3_reg    <= wq3_next;

        q4_reg     <= q4_next;
        dpp4_reg   <= dpp3_reg;
        wd4_reg    <= wd4_next;

        q5_reg     <= q4_reg;
        r5_reg     <= r5_next;
        wd5_reg    <= wd4_reg;

        year6_reg  <= year6_next;
        doy6_reg   <= doy6_next;
        leap6_reg  <= leap6_next;
        wd6_reg    <= wd5_reg;

        mon7_reg   <= mon7_next;
        year7_reg  <= year6_reg;
        doy7_reg   <= doy6_reg;
        leap7_reg  <= leap6_reg;
        wd7_reg    <= wd6_reg;

        mon8_reg   <= mon7_reg + 4'd1;
        dom8_reg   <= dom8_next;
        year8_reg  <= year7_reg;
        wd8_reg    <= wd7_reg;
    end

    assign out_valid    = vld_reg[5];
    assign year         = year8_reg;
    assign month        = mon8_reg;
    assign day_of_month = dom8_reg;
    assign weekday      = wd8_reg;

endmodule
`default_nettype wire

[hdl/epoch_seconds_to_calendar.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// unix seconds to gregorian date, time of day and weekday
// ----------------------------------------------------------------------------
// A transaction is taken at every rising edge where start is high; busy is
// always low, so one timestamp can enter each clock. The result appears
// at the pipeline output with done high for exactly one cycle and must be
// captured then: the block has no way to hold it. The pipeline has eight
// stages (two stages split days from seconds of the day, six more resolve
// the four-year cycle, month and day). Valid for every 32-bit input, i.e.
// 1970-01-01 through 2106-02-07; 2100 is handled as a non-leap year. No
// state is kept between transactions.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        start,
    output logic                       busy,
    input  wire  [esc_pkg::SecsW-1:0]  epoch_seconds,
    output logic                       done,
    output logic [esc_pkg::YearW-1:0]  year,
    output logic [esc_pkg::MonthW-1:0] month,
    output logic [esc_pkg::DomW-1:0]   day_of_month,
    output logic [esc_pkg::HourW-1:0]  hour,
    output logic [esc_pkg::MinW-1:0]   minute,
    output logic [esc_pkg::SecW-1:0]   second,
    output logic [esc_pkg::WdayW-1:0]  weekday
);
    import esc_pkg::*;

    // stage valid bits
    logic              vld1_reg;
    logic              vld2_reg;

    // stage 1: quotient by 86400 via reciprocal multiply of secs >> 7
    logic [50:0]       day_prod;
    logic [DaysW-1:0]  days1_reg, days1_next;
    logic [SecsW-1:0]  secs1_reg;

    // stage 2: seconds within the day
    logic [24:0]       day_hi;
    logic [24:0]       rem_hi;
    logic [DaysW-1:0]  days2_reg;
    logic [TodW-1:0]   tod2_reg, tod2_next;

    // pipeline never stalls; the receiver takes every result as it comes
    assign busy = 1'b0;

    always_comb
    begin
        day_prod   = 51'(epoch_seconds[SecsW-1:7]) * 51'(DayRecip);
        days1_next = day_prod[DayShift +: DaysW];
        day_hi     = 25'(days1_reg) * 25'(DayOdd);
        rem_hi     = secs1_reg[SecsW-1:7] - day_hi;
        // remainder of the high part stays below 675, low 7 bits pass through
        tod2_next  = {rem_hi[9:0], secs1_reg[6:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= start && !busy;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        days1_reg <= days1_next;
        secs1_reg <= epoch_seconds;
        days2_reg <= days1_reg;
        tod2_reg  <= tod2_next;
    end

    // date path: year, month, day and weekday, carries the valid bit
    esc_date u_date (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (vld2_reg),
        .days         (days2_reg),
        .out_valid    (done),
        .year         (year),
        .month        (month),
        .day_of_month (day_of_month),
        .weekday      (weekday)
    );

    // time path: same depth as the date path
    esc_tod u_tod (
        .clk    (clk),
        .tod    (tod2_reg),
        .hour   (hour),
        .minute (minute),
        .second (second)
    );

endmodule
`default_nettype wire

[hdl/esc_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// esc_checker
// port-level checks on the calendar converter, bound to the top level
// ----------------------------------------------------------------------------
module esc_checker (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        start,
    input  wire                        busy,
    input  wire                        done,
    input  wire  [esc_pkg::YearW-1:0]  year,
    input  wire  [esc_pkg::MonthW-1:0] month,
    input  wire  [esc_pkg::DomW-1:0]   day_of_month,
    input  wire  [esc_pkg::HourW-1:0]  hour,
    input  wire  [esc_pkg::MinW-1:0]   minute,
    input  wire  [esc_pkg::SecW-1:0]   second,
    input  wire  [esc_pkg::WdayW-1:0]  weekday
);
    import esc_pkg::*;

    // every result traces back to an accepted transaction at the pipeline input
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 8))
        else $error("done without a transaction eight cycles earlier");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (year >= 12'd1970) && (year <= 12'd2106) &&
                 (month >= 4'd1) && (month <= 4'd12) &&
                 (day_of_month >= 5'd1))
        else $error("date out of range");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hour < 5'd24) && (minute < 6'd60) && (second < 6'd60) &&
                 (weekday < 3'd7))
        else $error("time of day or weekday out of range");

    // short months never reach day 31, february never past 29
    a_month_length: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((month != 4'd2) || (day_of_month <= 5'd29)) &&
                 (!((month == 4'd4) || (month == 4'd6) || (month == 4'd9) ||
                    (month == 4'd11)) || (day_of_month <= 5'd30)))
        else $error("day of month beyond month length");

endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (.*);
`default_nettype wire
